@@ src/ultrasonic_echo_ranging_core_defines.svh @@
// Assertion macros shared by the ultrasonic echo ranging RTL.
// Include this header wherever assertions are written; it has no other dependencies.
`ifndef ULTRASONIC_ECHO_RANGING_CORE_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGING_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UER_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("uer assertion failed");

// The expression must never be true outside reset.
`define UER_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("uer assertion failed");

`endif

@@ src/uer_pkg.sv @@
// Package for the ultrasonic echo ranging core: types, register codes and constants.
// No dependencies; the core, uer_seq and uer_dist all import it.
package uer_pkg;

    localparam int CNT_W      = 20;
    localparam int TRIG_W     = 10;
    localparam int TMO_W      = 16;
    localparam int WIDTH_W    = 16;
    localparam int DIST_W     = 17;
    localparam int IDX_W      = 3;
    localparam int CFG_DATA_W = 32;

    // Distance = floor((width * 1000 + 291) / 582), done as one multiply by a
    // scaled reciprocal of 582 (exact for every 16-bit width) and a shift.
    localparam int PROD_W      = 53;
    localparam int RECIP_SHIFT = 36;
    localparam logic [PROD_W-1:0] DIST_MULT = 53'd118074703000;
    localparam logic [PROD_W-1:0] DIST_BIAS = 53'd34359738573;

    localparam logic [WIDTH_W-1:0] WIDTH_MAX = '1;

    localparam logic [CNT_W-1:0]  IDLE_PERIOD_RST   = 20'd1000000;
    localparam logic [TRIG_W-1:0] TRIGGER_WIDTH_RST = 10'd10;
    localparam logic [TMO_W-1:0]  ECHO_TIMEOUT_RST  = 16'd23280;
    localparam logic [DIST_W-1:0] MIN_DIST_RST      = 17'd200;
    localparam logic [DIST_W-1:0] MAX_DIST_RST      = 17'd40000;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TRIG = 2'd1,
        PH_WAIT = 2'd2,
        PH_ECHO = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_NONE    = 2'd0,
        ST_VALID   = 2'd1,
        ST_RANGE   = 2'd2,
        ST_TIMEOUT = 2'd3
    } status_t;

    typedef enum logic [IDX_W-1:0] {
        REG_IDLE_PERIOD   = 3'd0,
        REG_TRIGGER_WIDTH = 3'd1,
        REG_ECHO_TIMEOUT  = 3'd2,
        REG_MIN_DISTANCE  = 3'd3,
        REG_MAX_DISTANCE  = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [CNT_W-1:0]  idle_period;
        logic [TRIG_W-1:0] trigger_width;
        logic [TMO_W-1:0]  echo_timeout;
        logic [DIST_W-1:0] min_distance;
        logic [DIST_W-1:0] max_distance;
    } cfg_t;

    typedef struct packed {
        logic               trigger;
        logic               report;
        logic               timeout;
        logic [WIDTH_W-1:0] pulse_width;
    } meas_t;

endpackage

@@ src/ultrasonic_echo_ranging_core.sv @@
// Ultrasonic echo ranging core: one result word for every accepted tick word.
// An accepted input passes the sequencer, multiply and output registers before the result is valid.
// Throughput is one word per cycle while m_ready is high; the distance multiplier stage sets the clock path.
// Synchronous active-low reset returns to the idle phase with cleared counters,
// empties the pipeline and loads the configuration register defaults.
// Depends on uer_pkg, uer_seq, uer_dist and ultrasonic_echo_ranging_core_defines.svh.
`include "ultrasonic_echo_ranging_core_defines.svh"

module ultrasonic_echo_ranging_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [uer_pkg::IDX_W-1:0]         cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_echo_level,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_trigger_level,
    output logic                              m_report_valid,
    output logic [1:0]                        m_status_code,
    output logic [uer_pkg::WIDTH_W-1:0]       m_pulse_width_us,
    output logic [uer_pkg::DIST_W-1:0]        m_distance_centi
);
    import uer_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    logic  meas_valid;
    logic  meas_ready;
    meas_t meas;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index_t'(cfg_index))
                REG_IDLE_PERIOD:   cfg_next.idle_period   = cfg_data[CNT_W-1:0];
                REG_TRIGGER_WIDTH: cfg_next.trigger_width = cfg_data[TRIG_W-1:0];
                REG_ECHO_TIMEOUT:  cfg_next.echo_timeout  = cfg_data[TMO_W-1:0];
                REG_MIN_DISTANCE:  cfg_next.min_distance  = cfg_data[DIST_W-1:0];
                REG_MAX_DISTANCE:  cfg_next.max_distance  = cfg_data[DIST_W-1:0];
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.idle_period   <= IDLE_PERIOD_RST;
            cfg_reg.trigger_width <= TRIGGER_WIDTH_RST;
            cfg_reg.echo_timeout  <= ECHO_TIMEOUT_RST;
            cfg_reg.min_distance  <= MIN_DIST_RST;
            cfg_reg.max_distance  <= MAX_DIST_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    uer_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .echo_level (s_echo_level),
        .meas_valid (meas_valid),
        .meas_ready (meas_ready),
        .meas       (meas)
    );

    uer_dist u_dist (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg_reg),
        .meas_valid       (meas_valid),
        .meas_ready       (meas_ready),
        .meas             (meas),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_trigger_level  (m_trigger_level),
        .m_report_valid   (m_report_valid),
        .m_status_code    (m_status_code),
        .m_pulse_width_us (m_pulse_width_us),
        .m_distance_centi (m_distance_centi)
    );

    `UER_ASSERT_IMPLIES(a_empty_out_takes_input, aclk, aresetn, !m_valid, s_ready)
    `UER_ASSERT_IMPLIES(a_timeout_has_no_width, aclk, aresetn,
        m_valid && m_status_code == ST_TIMEOUT, m_pulse_width_us == '0 && m_distance_centi == '0)
    `UER_ASSERT_NEVER(a_status_matches_report, aclk, aresetn,
        m_valid && (m_report_valid == (m_status_code == ST_NONE)))

endmodule

@@ src/uer_seq.sv @@
// Measurement sequencer: trigger, echo wait and pulse width count, one tick per word.
// Depends on uer_pkg; feeds uer_dist through a registered meas_t word.
module uer_seq (
    input  logic           aclk,
    input  logic           aresetn,
    input  uer_pkg::cfg_t  cfg,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           echo_level,
    output logic           meas_valid,
    input  logic           meas_ready,
    output uer_pkg::meas_t meas
);
    import uer_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [WIDTH_W-1:0] width_reg, width_next;
    logic               valid_reg, valid_next;
    meas_t              meas_reg, meas_next;
    logic [CNT_W-1:0]   count_inc;
    logic               accept;

    assign in_ready   = !valid_reg || meas_ready;
    assign accept     = in_valid && in_ready;
    assign count_inc  = count_reg + 1'b1;
    assign meas_valid = valid_reg;
    assign meas       = meas_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
            width_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            width_reg <= width_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        meas_reg <= meas_next;
    end

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        width_next = width_reg;
        valid_next = valid_reg && !meas_ready;
        meas_next  = meas_reg;
        if (accept) begin
            valid_next = 1'b1;
            meas_next  = '0;
            case (phase_reg)
                PH_IDLE: begin
                    count_next = count_inc;
                    if (count_inc >= cfg.idle_period) begin
                        phase_next = PH_TRIG;
                        count_next = '0;
                    end
                end
                PH_TRIG: begin
                    meas_next.trigger = 1'b1;
                    count_next = count_inc;
                    if (count_inc >= CNT_W'(cfg.trigger_width)) begin
                        phase_next = PH_WAIT;
                        count_next = '0;
                    end
                end
                PH_WAIT: begin
                    if (echo_level) begin
                        phase_next = PH_ECHO;
                        count_next = '0;
                        width_next = WIDTH_W'(1);
                    end else begin
                        count_next = count_inc;
                        if (count_inc >= CNT_W'(cfg.echo_timeout)) begin
                            meas_next.report  = 1'b1;
                            meas_next.timeout = 1'b1;
                            phase_next = PH_IDLE;
                            count_next = '0;
                        end
                    end
                end
                PH_ECHO: begin
                    if (echo_level) begin
                        if (width_reg != WIDTH_MAX) begin
                            width_next = width_reg + 1'b1;
                        end
                    end else begin
                        meas_next.report      = 1'b1;
                        meas_next.pulse_width = width_reg;
                        phase_next = PH_IDLE;
                        count_next = '0;
                        width_next = '0;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

endmodule

@@ src/uer_dist.sv @@
// Distance stage: reciprocal multiply, range check and the output register.
// Depends on uer_pkg; takes meas_t words from uer_seq.
module uer_dist (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  uer_pkg::cfg_t                 cfg,
    input  logic                          meas_valid,
    output logic                          meas_ready,
    input  uer_pkg::meas_t                meas,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_trigger_level,
    output logic                          m_report_valid,
    output logic [1:0]                    m_status_code,
    output logic [uer_pkg::WIDTH_W-1:0]   m_pulse_width_us,
    output logic [uer_pkg::DIST_W-1:0]    m_distance_centi
);
    import uer_pkg::*;

    logic               prod_valid_reg, prod_valid_next;
    meas_t              prod_meas_reg;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic               prod_ready;

    logic               out_valid_reg, out_valid_next;
    logic               out_trig_reg;
    logic               out_report_reg;
    logic [1:0]         out_status_reg, out_status_next;
    logic [WIDTH_W-1:0] out_width_reg;
    logic [DIST_W-1:0]  out_dist_reg, out_dist_next;
    logic [DIST_W-1:0]  quotient;
    logic               in_range;

    assign meas_ready = !prod_valid_reg || prod_ready;
    assign prod_ready = !out_valid_reg || m_ready;

    assign prod_next       = PROD_W'(meas.pulse_width) * DIST_MULT + DIST_BIAS;
    assign prod_valid_next = (prod_valid_reg && !prod_ready) || meas_valid ||
                             (prod_valid_reg && !prod_ready);

    assign quotient = prod_reg[RECIP_SHIFT +: DIST_W];
    assign in_range = (quotient > cfg.min_distance) && (quotient < cfg.max_distance);

    always_comb begin
        out_status_next = ST_NONE;
        out_dist_next   = '0;
        if (prod_meas_reg.report) begin
            if (prod_meas_reg.timeout) begin
                out_status_next = ST_TIMEOUT;
            end else begin
                out_dist_next   = quotient;
                out_status_next = in_range ? ST_VALID : ST_RANGE;
            end
        end
    end

    assign out_valid_next = prod_valid_reg || (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (meas_ready) begin
                prod_valid_reg <= meas_valid;
            end
            if (prod_ready) begin
                out_valid_reg <= out_valid_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (meas_ready && prod_valid_next) begin
            prod_reg      <= prod_next;
            prod_meas_reg <= meas;
        end
        if (prod_ready && prod_valid_reg) begin
            out_trig_reg   <= prod_meas_reg.trigger;
            out_report_reg <= prod_meas_reg.report;
            out_status_reg <= out_status_next;
            out_width_reg  <= prod_meas_reg.pulse_width;
            out_dist_reg   <= out_dist_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_trigger_level  = out_trig_reg;
    assign m_report_valid   = out_report_reg;
    assign m_status_code    = out_status_reg;
    assign m_pulse_width_us = out_width_reg;
    assign m_distance_centi = out_dist_reg;

endmodule
